// ----- src/bpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types, widths and codes for the billboard point projection pipeline.
// ----------------------------------------------------------------------------
package bpp_pkg;

    // field widths
    localparam int POS_W  = 16;
    localparam int SIZE_W = 16;
    localparam int TEX_W  = 13;
    localparam int SCR_W  = 13;
    localparam int FOC_W  = 16;
    localparam int EDGE_W = 16;
    localparam int ROW_W  = 64;
    localparam int VEC_W  = 48;

    // internal widths
    localparam int PROD_W  = 32;                  // Q9.6 * Q3.12 product
    localparam int CLIP_W  = 34;                  // clip x, y, w
    localparam int DEPTH_W = 35;                  // eye depth, 20 fraction bits
    localparam int SF_W    = SIZE_W + FOC_W;      // size times focal
    localparam int TSF_W   = TEX_W + SF_W;        // texels times size times focal
    localparam int NXY_W   = SCR_W + 1 + CLIP_W + 1;
    localparam int M_W     = 53;                  // divider dividend
    localparam int B_W     = 35;                  // divider divisor
    localparam int Q_W     = 36;                  // divider quotient
    localparam int E_W     = Q_W + 3;             // rectangle edge before clamp

    // apb port
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    // depth limit 0.05 with 20 fraction bits
    localparam int NEAR_LIMIT = 52428;

    // reset values
    localparam logic [FOC_W-1:0] FOCAL_RST = FOC_W'(4096);
    localparam logic [SCR_W-1:0] SCR_W_RST = SCR_W'(640);
    localparam logic [SCR_W-1:0] SCR_H_RST = SCR_W'(480);

    // divider lanes
    localparam int NLANE = 4;
    localparam int LN_X  = 0;
    localparam int LN_Y  = 1;
    localparam int LN_W  = 2;
    localparam int LN_H  = 3;

    typedef enum logic [1:0] {
        ST_DRAWN  = 2'd0,
        ST_BEHIND = 2'd1,
        ST_NEAR   = 2'd2,
        ST_SMALL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_CLIP_X = 3'd0,
        REG_CLIP_Y = 3'd1,
        REG_CLIP_W = 3'd2,
        REG_CAM    = 3'd3,
        REG_FWD    = 3'd4,
        REG_FOCAL  = 3'd5,
        REG_SCR_W  = 3'd6,
        REG_SCR_H  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] clip_x;
        logic [ROW_W-1:0] clip_y;
        logic [ROW_W-1:0] clip_w;
        logic [VEC_W-1:0] cam;
        logic [VEC_W-1:0] fwd;
        logic [FOC_W-1:0] focal;
        logic [SCR_W-1:0] scr_w;
        logic [SCR_W-1:0] scr_h;
    } t_cfg;

    typedef struct packed {
        logic [M_W-1:0] m;
        logic [B_W-1:0] b;
        logic           neg;
    } t_div_req;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           neg;
    } t_div_res;

    typedef struct packed {
        t_status           status;
        logic [EDGE_W-1:0] left;
        logic [EDGE_W-1:0] top;
        logic [EDGE_W-1:0] right;
        logic [EDGE_W-1:0] bottom;
    } t_result;

endpackage

// ----- src/bpp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_front
// Clip transform, eye depth, cull tests and rounding set-up for the four
// divisions (center x, center y, width, height). Seven register stages.
// ----------------------------------------------------------------------------
module bpp_front import bpp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [SIZE_W-1:0]        i_sprite_size,
    input  logic [TEX_W-1:0]         i_tex_width,
    input  logic [TEX_W-1:0]         i_tex_height,
    output logic                     o_valid,
    output t_status                  o_status,
    output t_div_req [NLANE-1:0]     o_req
);

    logic [6:0] r_v;

    // stage 0: input word
    logic signed [POS_W-1:0] r0_p [3];
    logic [SIZE_W-1:0]       r0_size;
    logic [TEX_W-1:0]        r0_tw, r0_th;

    // stage 1: products
    logic signed [PROD_W-1:0]  r1_cp [3][3];
    logic signed [PROD_W:0]    r1_dp [3];
    logic [SF_W-1:0]           r1_sf;
    logic [TEX_W-1:0]          r1_tw, r1_th;

    // stage 2: sums
    logic signed [CLIP_W-1:0]  r2_c [3];
    logic signed [DEPTH_W-1:0] r2_z;
    logic [SF_W-1:0]           r2_sf;
    logic [TSF_W-1:0]          r2_tws, r2_ths;

    // stage 3: cull and center sums
    t_status                   r3_st;
    logic signed [CLIP_W:0]    r3_sx, r3_sy;
    logic signed [CLIP_W-1:0]  r3_cw;
    logic signed [DEPTH_W-1:0] r3_z;
    logic [TSF_W-1:0]          r3_tws, r3_ths;

    // stage 4: numerators
    t_status                   r4_st;
    logic signed [NXY_W-1:0]   r4_nx, r4_ny;
    logic [TSF_W-1:0]          r4_tws, r4_ths;
    logic signed [CLIP_W-1:0]  r4_cw;
    logic signed [DEPTH_W-1:0] r4_z;

    // stage 5: rounded dividends
    t_status                   r5_st;
    logic [M_W-1:0]            r5_a [NLANE];
    logic [B_W-1:0]            r5_b [NLANE];

    // stage 6: divider requests
    t_status                   r6_st;
    t_div_req [NLANE-1:0]      r6_req;

    logic [ROW_W-1:0]          w_row [3];
    logic signed [POS_W:0]     w_d [3];
    logic signed [CLIP_W-1:0]  w_c [3];
    logic signed [DEPTH_W-1:0] w_z;
    logic [SF_W+5:0]           w_sf50;
    logic                      w_behind, w_near, w_small;
    t_status                   w_st;
    logic signed [M_W-1:0]     w_a [NLANE];
    logic [M_W-1:0]            w_m [NLANE];

    assign w_row[0] = i_cfg.clip_x;
    assign w_row[1] = i_cfg.clip_y;
    assign w_row[2] = i_cfg.clip_w;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // position relative to camera
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k] = (POS_W+1)'(r0_p[k])
                   - (POS_W+1)'($signed(i_cfg.cam[16*k +: 16]));
        end
    end

    // row sums with the constant term scaled by 1.0 in Q9.6
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_c[r] = CLIP_W'(r1_cp[r][0]) + CLIP_W'(r1_cp[r][1])
                   + CLIP_W'(r1_cp[r][2])
                   + (CLIP_W'($signed(w_row[r][63:48])) <<< 6);
        end
        w_z = DEPTH_W'(r1_dp[0]) + DEPTH_W'(r1_dp[1]) + DEPTH_W'(r1_dp[2]);
    end

    // cull tests, behind camera first
    always_comb begin
        w_sf50   = (SF_W+6)'({r2_sf, 5'b0}) + (SF_W+6)'({r2_sf, 4'b0})
                 + (SF_W+6)'({r2_sf, 1'b0});
        w_behind = (r2_c[2] <= 0);
        w_near   = (r2_z <= DEPTH_W'(NEAR_LIMIT));
        w_small  = ($signed({1'b0, w_sf50}) < (SF_W+7)'(r2_z));
        if (w_behind) begin
            w_st = ST_BEHIND;
        end else if (w_near) begin
            w_st = ST_NEAR;
        end else if (w_small) begin
            w_st = ST_SMALL;
        end else begin
            w_st = ST_DRAWN;
        end
    end

    // dividends 2*num + den for round to nearest
    always_comb begin
        w_a[LN_X] = (M_W'(r4_nx) <<< 4) + M_W'(r4_cw);
        w_a[LN_Y] = (M_W'(r4_ny) <<< 4) + M_W'(r4_cw);
        w_a[LN_W] = (M_W'($signed({1'b0, r4_tws})) <<< 5) + M_W'(r4_z);
        w_a[LN_H] = (M_W'($signed({1'b0, r4_ths})) <<< 5) + M_W'(r4_z);
    end

    // floor division of a negative dividend works on |a| + b - 1
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            if (r5_a[l][M_W-1]) begin
                w_m[l] = M_W'(r5_b[l]) - r5_a[l] - M_W'(1);
            end else begin
                w_m[l] = r5_a[l];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_p[0] <= i_pos_x;
            r0_p[1] <= i_pos_y;
            r0_p[2] <= i_pos_z;
            r0_size <= i_sprite_size;
            r0_tw   <= i_tex_width;
            r0_th   <= i_tex_height;

            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_cp[r][k] <= $signed(w_row[r][16*k +: 16]) * r0_p[k];
                end
            end
            for (int k = 0; k < 3; k++) begin
                r1_dp[k] <= w_d[k] * $signed(i_cfg.fwd[16*k +: 16]);
            end
            r1_sf <= r0_size * i_cfg.focal;
            r1_tw <= r0_tw;
            r1_th <= r0_th;

            r2_c   <= w_c;
            r2_z   <= w_z;
            r2_sf  <= r1_sf;
            r2_tws <= r1_tw * r1_sf;
            r2_ths <= r1_th * r1_sf;

            r3_st  <= w_st;
            r3_sx  <= (CLIP_W+1)'(r2_c[0]) + (CLIP_W+1)'(r2_c[2]);
            r3_sy  <= (CLIP_W+1)'(r2_c[2]) - (CLIP_W+1)'(r2_c[1]);
            r3_cw  <= r2_c[2];
            r3_z   <= r2_z;
            r3_tws <= r2_tws;
            r3_ths <= r2_ths;

            r4_st  <= r3_st;
            r4_nx  <= $signed({1'b0, i_cfg.scr_w}) * r3_sx;
            r4_ny  <= $signed({1'b0, i_cfg.scr_h}) * r3_sy;
            r4_tws <= r3_tws;
            r4_ths <= r3_ths;
            r4_cw  <= r3_cw;
            r4_z   <= r3_z;

            r5_st <= r4_st;
            for (int l = 0; l < NLANE; l++) begin
                r5_a[l] <= w_a[l];
            end
            r5_b[LN_X] <= B_W'({r4_cw, 1'b0});
            r5_b[LN_Y] <= B_W'({r4_cw, 1'b0});
            r5_b[LN_W] <= B_W'({r4_z, 1'b0});
            r5_b[LN_H] <= B_W'({r4_z, 1'b0});

            r6_st <= r5_st;
            for (int l = 0; l < NLANE; l++) begin
                r6_req[l].m   <= w_m[l];
                r6_req[l].b   <= r5_b[l];
                r6_req[l].neg <= r5_a[l][M_W-1];
            end
        end
    end

    assign o_valid  = r_v[6];
    assign o_status = r6_st;
    assign o_req    = r6_req;

endmodule

// ----- src/bpp_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_div
// Pipelined restoring divider, one quotient bit per stage. A quotient that
// does not fit is clamped to all ones.
// ----------------------------------------------------------------------------
module bpp_div import bpp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_div_req i_req,
    output t_div_res o_res
);

    logic [B_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0] r_lo  [Q_W];
    logic [B_W-1:0] r_b   [Q_W];
    logic [Q_W-1:0] r_q   [Q_W+1];
    logic           r_neg [Q_W+1];
    logic           r_ovf [Q_W+1];

    logic [B_W:0]   w_t  [Q_W];
    logic [B_W:0]   w_df [Q_W];
    logic           w_ge [Q_W];

    // trial subtract per stage
    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            w_t[k]  = {r_rem[k], r_lo[k][Q_W-1]};
            w_ge[k] = (w_t[k] >= {1'b0, r_b[k]});
            w_df[k] = w_t[k] - {1'b0, r_b[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // entry: upper dividend bits seed the remainder
            r_rem[0] <= B_W'(i_req.m[M_W-1:Q_W]);
            r_lo[0]  <= i_req.m[Q_W-1:0];
            r_b[0]   <= i_req.b;
            r_q[0]   <= '0;
            r_neg[0] <= i_req.neg;
            r_ovf[0] <= (B_W'(i_req.m[M_W-1:Q_W]) >= i_req.b);
            for (int k = 1; k < Q_W; k++) begin
                r_rem[k] <= w_ge[k-1] ? w_df[k-1][B_W-1:0] : w_t[k-1][B_W-1:0];
                r_lo[k]  <= {r_lo[k-1][Q_W-2:0], 1'b0};
                r_b[k]   <= r_b[k-1];
            end
            for (int k = 1; k <= Q_W; k++) begin
                r_q[k]   <= {r_q[k-1][Q_W-2:0], w_ge[k-1]};
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_res.q   = r_ovf[Q_W] ? '1 : r_q[Q_W];
    assign o_res.neg = r_neg[Q_W];

endmodule

// ----- src/bpp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_back
// Signs the quotients, centers the rectangle on the screen point and clamps
// each edge to 16 bits (zero for a culled word). Two register stages.
// ----------------------------------------------------------------------------
module bpp_back import bpp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_status              i_status,
    input  t_div_res [NLANE-1:0] i_res,
    output logic                 o_valid,
    output t_result              o_res
);

    localparam logic signed [E_W-1:0] SAT_HI = E_W'((2 ** (EDGE_W - 1)) - 1);
    localparam logic signed [E_W-1:0] SAT_LO = -SAT_HI - E_W'(1);

    logic                r1_v, r2_v;
    t_status             r1_st;
    logic signed [Q_W:0] r1_s [NLANE];
    t_result             r2_res;

    logic signed [Q_W:0]   w_hw, w_hh;
    logic signed [E_W-1:0] w_left, w_top, w_right, w_bottom;
    t_result               w_res;

    function automatic logic [EDGE_W-1:0] sat_edge(input logic signed [E_W-1:0] v);
        logic [EDGE_W-1:0] s;
        if (v > SAT_HI) begin
            s = SAT_HI[EDGE_W-1:0];
        end else if (v < SAT_LO) begin
            s = SAT_LO[EDGE_W-1:0];
        end else begin
            s = v[EDGE_W-1:0];
        end
        return s;
    endfunction

    // edges from center and size
    always_comb begin
        w_hw     = r1_s[LN_W] >>> 1;
        w_hh     = r1_s[LN_H] >>> 1;
        w_left   = E_W'(r1_s[LN_X]) - E_W'(w_hw);
        w_top    = E_W'(r1_s[LN_Y]) - E_W'(w_hh);
        w_right  = w_left + E_W'(r1_s[LN_W]);
        w_bottom = w_top + E_W'(r1_s[LN_H]);
        w_res.status = r1_st;
        if (r1_st == ST_DRAWN) begin
            w_res.left   = sat_edge(w_left);
            w_res.top    = sat_edge(w_top);
            w_res.right  = sat_edge(w_right);
            w_res.bottom = sat_edge(w_bottom);
        end else begin
            w_res.left   = '0;
            w_res.top    = '0;
            w_res.right  = '0;
            w_res.bottom = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    // signed quotients, then result word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_st <= i_status;
            for (int l = 0; l < NLANE; l++) begin
                if (i_res[l].neg) begin
                    r1_s[l] <= -$signed({1'b0, i_res[l].q});
                end else begin
                    r1_s[l] <= $signed({1'b0, i_res[l].q});
                end
            end
            r2_res <= w_res;
        end
    end

    assign o_valid = r2_v;
    assign o_res   = r2_res;

endmodule

// ----- src/billboard_point_projection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// billboard_point_projection
// Projects a world point through the view-projection rows, culls it and
// returns the screen rectangle of a camera-facing sprite.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  input     | i_valid / o_ready      | i_pos_x/y/z, i_sprite_size, i_tex_*
//  output    | o_valid / i_ready      | o_status, o_rect_left/top/right/bottom
//  config    | psel, penable, pwrite  | paddr, pwdata, prdata (64-bit data)
//
//  one word per cycle while o_ready is high; center and size come from the
//  36-step restoring divider pipeline
//  one enable moves the whole pipeline; a skid register behind the output
//  register keeps input taking words while a result waits
//  o_ready drops only while the skid register is full
//  reset is synchronous; it clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
module billboard_point_projection import bpp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [SIZE_W-1:0]        i_sprite_size,
    input  logic [TEX_W-1:0]         i_tex_width,
    input  logic [TEX_W-1:0]         i_tex_height,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic signed [EDGE_W-1:0] o_rect_left,
    output logic signed [EDGE_W-1:0] o_rect_top,
    output logic signed [EDGE_W-1:0] o_rect_right,
    output logic signed [EDGE_W-1:0] o_rect_bottom,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    t_cfg                 r_cfg;
    logic                 w_en;
    t_reg_idx             w_idx;

    logic                 w_f_v;
    t_status              w_f_st;
    t_div_req [NLANE-1:0] w_req;
    t_div_res [NLANE-1:0] w_res;

    logic [Q_W:0]         r_dl_v;
    t_status              r_dl_st [Q_W+1];

    logic                 w_pv;
    t_result              w_pd;

    logic                 r_o_v, r_s_v;
    t_result              r_o, r_s;

    assign w_en    = !r_s_v;
    assign o_ready = w_en;
    assign pready  = 1'b1;
    assign w_idx   = t_reg_idx'(paddr[5:3]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_x <= '0;
            r_cfg.clip_y <= '0;
            r_cfg.clip_w <= '0;
            r_cfg.cam    <= '0;
            r_cfg.fwd    <= '0;
            r_cfg.focal  <= FOCAL_RST;
            r_cfg.scr_w  <= SCR_W_RST;
            r_cfg.scr_h  <= SCR_H_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_CLIP_X: r_cfg.clip_x <= pwdata;
                REG_CLIP_Y: r_cfg.clip_y <= pwdata;
                REG_CLIP_W: r_cfg.clip_w <= pwdata;
                REG_CAM:    r_cfg.cam    <= pwdata[VEC_W-1:0];
                REG_FWD:    r_cfg.fwd    <= pwdata[VEC_W-1:0];
                REG_FOCAL:  r_cfg.focal  <= pwdata[FOC_W-1:0];
                REG_SCR_W:  r_cfg.scr_w  <= pwdata[SCR_W-1:0];
                REG_SCR_H:  r_cfg.scr_h  <= pwdata[SCR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (w_idx)
            REG_CLIP_X: prdata = r_cfg.clip_x;
            REG_CLIP_Y: prdata = r_cfg.clip_y;
            REG_CLIP_W: prdata = r_cfg.clip_w;
            REG_CAM:    prdata = APB_DW'(r_cfg.cam);
            REG_FWD:    prdata = APB_DW'(r_cfg.fwd);
            REG_FOCAL:  prdata = APB_DW'(r_cfg.focal);
            REG_SCR_W:  prdata = APB_DW'(r_cfg.scr_w);
            REG_SCR_H:  prdata = APB_DW'(r_cfg.scr_h);
            default:    prdata = '0;
        endcase
    end

    bpp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_sprite_size (i_sprite_size),
        .i_tex_width   (i_tex_width),
        .i_tex_height  (i_tex_height),
        .o_valid       (w_f_v),
        .o_status      (w_f_st),
        .o_req         (w_req)
    );

    // four dividers in lockstep
    for (genvar l = 0; l < NLANE; l++) begin : g_div
        bpp_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_req (w_req[l]),
            .o_res (w_res[l])
        );
    end

    // valid and status ride alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_v <= '0;
        end else if (w_en) begin
            r_dl_v <= {r_dl_v[Q_W-1:0], w_f_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_st[0] <= w_f_st;
            for (int k = 1; k <= Q_W; k++) begin
                r_dl_st[k] <= r_dl_st[k-1];
            end
        end
    end

    bpp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_dl_v[Q_W]),
        .i_status (r_dl_st[Q_W]),
        .i_res    (w_res),
        .o_valid  (w_pv),
        .o_res    (w_pd)
    );

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (!r_o_v || i_ready) begin
            if (r_s_v) begin
                r_o_v <= 1'b1;
                r_s_v <= 1'b0;
            end else begin
                r_o_v <= w_pv;
            end
        end else if (w_pv && !r_s_v) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_v || i_ready) begin
            r_o <= r_s_v ? r_s : w_pd;
        end else if (w_pv && !r_s_v) begin
            r_s <= w_pd;
        end
    end

    assign o_valid       = r_o_v;
    assign o_status      = r_o.status;
    assign o_rect_left   = r_o.left;
    assign o_rect_top    = r_o.top;
    assign o_rect_right  = r_o.right;
    assign o_rect_bottom = r_o.bottom;

    // skid only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |-> r_o_v)
        else $error("skid word without output word");

    // skid word stays while output is stalled
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v && !i_ready |=> r_s_v)
        else $error("skid word lost during stall");

    // culled word carries an empty rectangle
    a_cull_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && (r_o.status != ST_DRAWN) |->
        (r_o.left == '0) && (r_o.top == '0) && (r_o.right == '0) && (r_o.bottom == '0))
        else $error("culled word with nonzero rectangle");

    // drawn rectangle is never inverted
    a_rect_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && (r_o.status == ST_DRAWN) |->
        ($signed(r_o.right) >= $signed(r_o.left)) &&
        ($signed(r_o.bottom) >= $signed(r_o.top)))
        else $error("inverted rectangle");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// billboard point projection testbench
// Drives sprite points through the projection block with random gaps and
// output stalls, predicts each rectangle in the testbench and compares every
// returned word field by field. Register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;
    import bpp_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
    } t_rect;

    // scoreboard: holds the register copy and the rectangles still owed
    class rect_scoreboard;
        logic [63:0] clip_x, clip_y, clip_w;
        logic [47:0] cam, fwd;
        logic [15:0] focal;
        logic [12:0] scr_w, scr_h;
        t_rect       owed[$];
        int          errors;

        function void reset_regs();
            clip_x = 0; clip_y = 0; clip_w = 0; cam = 0; fwd = 0;
            focal = 4096; scr_w = 640; scr_h = 480;
        endfunction

        function void set_reg(t_reg_idx idx, logic [63:0] v);
            case (idx)
                REG_CLIP_X: clip_x = v;
                REG_CLIP_Y: clip_y = v;
                REG_CLIP_W: clip_w = v;
                REG_CAM:    cam = v[47:0];
                REG_FWD:    fwd = v[47:0];
                REG_FOCAL:  focal = v[15:0];
                REG_SCR_W:  scr_w = v[12:0];
                REG_SCR_H:  scr_h = v[12:0];
                default: ;
            endcase
        endfunction

        function longint lane_of(logic [63:0] w, int k);
            logic signed [15:0] s;
            s = w[16*k +: 16];
            return longint'(s);
        endfunction

        function longint round_div(longint num, longint den);
            longint a, b, q;
            a = 2 * num + den;
            b = 2 * den;
            q = a / b;
            if ((a % b) != 0 && a < 0) q = q - 1;
            return q;
        endfunction

        function logic [15:0] clamp16(longint v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function longint row_sum(logic [63:0] row, longint p[3]);
            return lane_of(row, 0) * p[0] + lane_of(row, 1) * p[1]
                 + lane_of(row, 2) * p[2] + lane_of(row, 3) * 64;
        endfunction

        // project one accepted point and queue its rectangle
        function void note_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                 logic [15:0] size, logic [12:0] tw, logic [12:0] th);
            longint p[3];
            longint cx, cy, cw, z, sz, sx, sy, wq, hq, lft, tp;
            t_rect  r;
            p[0] = longint'(signed'(px));
            p[1] = longint'(signed'(py));
            p[2] = longint'(signed'(pz));
            sz = longint'(size);
            r = '{ST_DRAWN, 0, 0, 0, 0};
            cx = row_sum(clip_x, p);
            cy = row_sum(clip_y, p);
            cw = row_sum(clip_w, p);
            z = 0;
            for (int k = 0; k < 3; k++)
                z += (p[k] - lane_of(cam, k)) * lane_of(fwd, k);
            if (cw <= 0) begin
                r.status = ST_BEHIND;
            end else if (z * 20 <= (64'sd1 <<< 20)) begin
                r.status = ST_NEAR;
            end else if (50 * sz * longint'(focal) < z) begin
                r.status = ST_SMALL;
            end else begin
                sx = round_div(8 * longint'(scr_w) * (cx + cw), cw);
                sy = round_div(8 * longint'(scr_h) * (cw - cy), cw);
                wq = round_div(16 * longint'(tw) * sz * longint'(focal), z);
                hq = round_div(16 * longint'(th) * sz * longint'(focal), z);
                lft = sx - wq / 2;
                tp = sy - hq / 2;
                r.left = clamp16(lft);
                r.top = clamp16(tp);
                r.right = clamp16(lft + wq);
                r.bottom = clamp16(tp + hq);
            end
            owed.push_back(r);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_rect(t_rect got);
            t_rect want;
            if (owed.size() == 0) begin
                report("unexpected word", 16'(got.status), 16'h0);
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status) report("status", 16'(got.status), 16'(want.status));
            if (got.left !== want.left) report("left", got.left, want.left);
            if (got.top !== want.top) report("top", got.top, want.top);
            if (got.right !== want.right) report("right", got.right, want.right);
            if (got.bottom !== want.bottom) report("bottom", got.bottom, want.bottom);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, o_ready, o_valid, i_ready = 0;
    logic signed [15:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic [15:0] i_sprite_size = 0;
    logic [12:0] i_tex_width = 1, i_tex_height = 1;
    logic [1:0] o_status;
    logic signed [15:0] o_rect_left, o_rect_top, o_rect_right, o_rect_bottom;
    logic psel = 0, penable = 0, pwrite = 0, pready;
    logic [APB_AW-1:0] paddr = 0;
    logic [63:0] pwdata = 0, prdata;

    rect_scoreboard sb;
    longint cycles = 0;
    bit     out_stall_on = 1;
    int     stall_left = 0;

    localparam longint CYCLE_LIMIT = 400000;

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    billboard_point_projection i_dut (.*);

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // output side: random stalls, a few long ones, check accepted words
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_rect('{o_status, o_rect_left, o_rect_top, o_rect_right, o_rect_bottom});
        if (!out_stall_on)
            i_ready <= 1;
        else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 0;
        end else if ($urandom_range(0, 199) == 0) begin
            stall_left <= $urandom_range(10, 50);
            i_ready <= 0;
        end else if ($urandom_range(0, 99) < 3)
            i_ready <= 0;
        else if ($urandom_range(0, 99) < 70)
            i_ready <= 1;
        else
            i_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic write_reg(t_reg_idx idx, logic [63:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= APB_AW'(8 * int'(idx)); pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    // valid stays high into the next word when there is no gap
    task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                              logic [15:0] size, logic [12:0] tw, logic [12:0] th);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
              ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_sprite_size <= size; i_tex_width <= tw; i_tex_height <= th;
        do @(posedge i_clk); while (!o_ready);
        sb.note_point(px, py, pz, size, tw, th);
    endtask

    // stop sending and wait until everything owed has come back
    task automatic wait_owed();
        i_valid <= 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        wait_owed();
        repeat (60) @(posedge i_clk);
    endtask

    // a random well-formed point in front of the camera, sometimes pure noise
    task automatic send_random();
        logic [15:0] px, py, pz, size;
        logic [12:0] tw, th;
        px = $urandom; py = $urandom; pz = $urandom;
        size = $urandom; tw = $urandom; th = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            px = 16'($signed($urandom_range(0, 1280)) - 640);
            py = 16'($signed($urandom_range(0, 1280)) - 640);
            pz = 16'($urandom_range(100, 8000));
            size = 16'($urandom_range(1, 1024));
            tw = 13'($urandom_range(1, 256));
            th = 13'($urandom_range(1, 256));
        end
        send_point(px, py, pz, size, tw, th);
    endtask

    // typical camera: identity-like rows with w taken from z, looking down +z
    task automatic camera_setup(logic [15:0] foc, logic [12:0] sw, logic [12:0] sh);
        write_reg(REG_CLIP_X, {16'h0000, 16'h0000, 16'h0000, 16'h1000});
        write_reg(REG_CLIP_Y, {16'h0000, 16'h0000, 16'h1000, 16'h0000});
        write_reg(REG_CLIP_W, {16'h0000, 16'h1000, 16'h0000, 16'h0000});
        write_reg(REG_CAM, 48'h0);
        write_reg(REG_FWD, {16'h4000, 16'h0000, 16'h0000});
        write_reg(REG_FOCAL, 64'(foc));
        write_reg(REG_SCR_W, 64'(sw));
        write_reg(REG_SCR_H, 64'(sh));
    endtask

    initial begin
        sb = new();
        sb.reset_regs();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset values: all-zero rows put every point behind the camera
        send_point(16'h0100, 16'h0100, 16'h0100, 16'h0100, 13'd16, 13'd16);
        drain();

        // directed: culls, extremes, zero sizes
        camera_setup(16'd4096, 13'd640, 13'd480);
        send_point(16'h0000, 16'h0000, 16'hFF00, 16'h0100, 13'd16, 13'd16);
        send_point(16'h0000, 16'h0000, 16'h0001, 16'h0100, 13'd16, 13'd16);
        send_point(16'h0000, 16'h0000, 16'h0003, 16'h0100, 13'd16, 13'd16);
        send_point(16'h0000, 16'h0000, 16'h0004, 16'h0100, 13'd16, 13'd16);
        send_point(16'h0000, 16'h0000, 16'h0400, 16'h0000, 13'd16, 13'd16);
        send_point(16'h0000, 16'h0000, 16'h7FFF, 16'h0001, 13'd16, 13'd16);
        send_point(16'h0000, 16'h0000, 16'h0040, 16'h0100, 13'd0, 13'd0);
        send_point(16'h7FFF, 16'h8000, 16'h0040, 16'hFFFF, 13'h1FFF, 13'h1FFF);
        send_point(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 13'd4096, 13'd1);
        send_point(16'hFFFF, 16'hFFFF, 16'h0100, 16'h0080, 13'd1, 13'd4096);
        send_point(16'h0040, 16'hFFC0, 16'h0080, 16'h0200, 13'd64, 13'd32);
        drain();

        // zero focal factor, zero screen
        camera_setup(16'd0, 13'd0, 13'd0);
        send_point(16'h0010, 16'h0010, 16'h0200, 16'h0100, 13'd16, 13'd16);
        drain();
        write_reg(REG_FOCAL, 64'hFFFF);
        send_point(16'h0010, 16'h0010, 16'h0200, 16'h0100, 13'd16, 13'd16);
        drain();

        // random phases with several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: camera_setup(16'd4096, 13'd640, 13'd480);
                1: camera_setup(16'hFFFF, 13'h1FFF, 13'h1FFF);
                2: camera_setup(16'd1, 13'd1, 13'd1);
                3: begin
                    out_stall_on = 0;
                    camera_setup(16'd6000, 13'd1920, 13'd1080);
                    write_reg(REG_CAM, {16'($urandom_range(0, 200)), 16'h0020, 16'hFFE0});
                    write_reg(REG_FWD, {16'h3800, 16'h1000, 16'hF000});
                end
                4: begin
                    out_stall_on = 1;
                    write_reg(REG_CLIP_X, {$urandom, $urandom});
                    write_reg(REG_CLIP_Y, {$urandom, $urandom});
                    write_reg(REG_CLIP_W, {$urandom, $urandom});
                    write_reg(REG_CAM, {$urandom, $urandom});
                    write_reg(REG_FWD, {$urandom, $urandom});
                    write_reg(REG_FOCAL, 64'($urandom));
                end
                default: begin
                    write_reg(REG_CLIP_X, 64'hFFFF_FFFF_FFFF_FFFF);
                    write_reg(REG_CLIP_Y, 64'h8000_8000_8000_8000);
                    write_reg(REG_CLIP_W, 64'h7FFF_7FFF_7FFF_7FFF);
                    write_reg(REG_CAM, 48'h8000_8000_8000);
                    write_reg(REG_FWD, 48'h7FFF_7FFF_7FFF);
                end
            endcase
            for (int n = 0; n < 120; n++) begin
                send_random();
                // hold off once until everything owed has come back
                if (ph == 0 && n == 60)
                    wait_owed();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/bpp_pkg.sv
src/bpp_front.sv
src/bpp_div.sv
src/bpp_back.sv
src/billboard_point_projection.sv
sim/testbench.sv
